// File: sv/srsw_pkg.sv
// Package for the selective-repeat sender window: codes, types and sizes.
`default_nettype none
package srsw_pkg;

  localparam int unsigned WindowSlotsDefault = 64;
  localparam int unsigned TimeoutReset = 20;
  localparam int unsigned LimitReset = 64;

  localparam int unsigned SeqW = 32;
  localparam int unsigned SackW = 64;
  localparam int unsigned OpW = 3;
  localparam int unsigned KindW = 3;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned LimitW = 7;
  localparam int unsigned CntW = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [OpW-1:0] OP_CHUNK = 3'd0;
  localparam logic [OpW-1:0] OP_END = 3'd1;
  localparam logic [OpW-1:0] OP_ACK = 3'd2;
  localparam logic [OpW-1:0] OP_FINACK = 3'd3;
  localparam logic [OpW-1:0] OP_TICK = 3'd4;

  localparam logic [KindW-1:0] KIND_SEND = 3'd0;
  localparam logic [KindW-1:0] KIND_RESEND = 3'd1;
  localparam logic [KindW-1:0] KIND_FIN = 3'd2;
  localparam logic [KindW-1:0] KIND_FULL = 3'd3;
  localparam logic [KindW-1:0] KIND_STATUS = 3'd4;

  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LIMIT = 2'd1;

  typedef enum logic [2:0] {
    CMD_CHUNK,
    CMD_END,
    CMD_ACK,
    CMD_FINACK,
    CMD_TICK,
    CMD_NOP
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e           op;
    logic [SeqW-1:0]   ack_cum;
    logic [SackW-1:0]  sack_map;
  } cmd_t;

endpackage
`default_nettype wire

// File: sv/srsw_if.sv
// Handshake interfaces for the input items and the result items.
`default_nettype none
interface srsw_in_if;
  logic                        valid;
  logic                        ready;
  logic [srsw_pkg::OpW-1:0]    opcode;
  logic [srsw_pkg::SeqW-1:0]   ack_cum;
  logic [srsw_pkg::SackW-1:0]  sack_map;
  modport source (output valid, output opcode, output ack_cum, output sack_map,
                  input ready);
  modport sink (input valid, input opcode, input ack_cum, input sack_map,
                output ready);
endinterface

interface srsw_out_if;
  logic                        valid;
  logic                        ready;
  logic [srsw_pkg::KindW-1:0]  kind;
  logic [srsw_pkg::SeqW-1:0]   seq_number;
  logic [srsw_pkg::SeqW-1:0]   window_base;
  logic                        done_res;
  logic                        last;
  modport source (output valid, output kind, output seq_number, output window_base,
                  output done_res, output last, input ready);
  modport sink (input valid, input kind, input seq_number, input window_base,
                input done_res, input last, output ready);
endinterface
`default_nettype wire

// File: sv/selective_repeat_sender_window.sv
// Top level of the selective-repeat sender window with configuration registers.
//
// The block is the bookkeeping half of a selective-repeat ARQ sender. Input
// beats on item_i carry an opcode (new chunk, end of data, ack, FIN-ACK or
// timer tick) with the cumulative ack base and the 64-bit SACK map; result
// beats on res_o tell the host what to send (data, resend, FIN), that the
// window is full, or just the status, and the last result of each input
// carries last = 1.
// A chunk, end of data or FIN-ACK passes from S_IDLE through S_DONE into
// the result register. An ack walks every slot in flight once, one slot a
// cycle, and then goes to S_DONE; a tick walks the same way, one slot a
// cycle through the read port of the slot memory while the result register
// can take a beat, then checks the FIN in S_TICKF. Items are carried out one
// at a time; a two-beat queue behind the input lets the sender hand over
// the next items meanwhile.
// Reset clears the window, the sequence counter, the flags and the tick
// count; the slot memory needs no clearing, as a slot is always written by
// a send before it is read. When the receiver holds res_o.ready low, a
// tick walk stops in place and resumes with nothing lost; the queue then fills
// and item_i.ready falls.
// Configuration writes (timeout in ticks, window limit) are taken at any
// clock edge with cfg_we_i high and should be made while the block is idle.
`default_nettype none
module selective_repeat_sender_window #(
  parameter int unsigned WindowSlots = srsw_pkg::WindowSlotsDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  srsw_in_if.sink                             item_i,
  srsw_out_if.source                          res_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [srsw_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [srsw_pkg::CfgDataW-1:0]  cfg_data_i
);

  // Configuration registers; the limit is clamped where it is used.
  logic [srsw_pkg::TimeoutW-1:0] timeout_q;
  logic [srsw_pkg::LimitW-1:0]   limit_q;

  srsw_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= srsw_pkg::TimeoutW'(srsw_pkg::TimeoutReset);
      limit_q <= srsw_pkg::LimitW'(srsw_pkg::LimitReset);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        srsw_pkg::CFG_TIMEOUT: timeout_q <= cfg_data_i;
        srsw_pkg::CFG_LIMIT:   limit_q <= cfg_data_i[srsw_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  // The front classifies beats and queues them as commands.
  srsw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  // The back keeps the window and produces the result beats.
  srsw_back #(
    .WindowSlots (WindowSlots)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .timeout_i   (timeout_q),
    .limit_i     (limit_q),
    .res_o       (res_o)
  );

endmodule
`default_nettype wire

// File: sv/srsw_front.sv
// Front part: accepts input beats, classifies the opcode and queues commands.
`default_nettype none
module srsw_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  srsw_in_if.sink             item_i,
  output srsw_pkg::cmd_t      cmd_o,
  output logic                cmd_valid_o,
  input  wire logic           cmd_pop_i
);

  srsw_pkg::cmd_t cls;
  srsw_pkg::cmd_t fifo_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           push;
  logic           pop;

  always_comb begin
    cls.ack_cum = item_i.ack_cum;
    cls.sack_map = item_i.sack_map;
    case (item_i.opcode)
      srsw_pkg::OP_CHUNK:  cls.op = srsw_pkg::CMD_CHUNK;
      srsw_pkg::OP_END:    cls.op = srsw_pkg::CMD_END;
      srsw_pkg::OP_ACK:    cls.op = srsw_pkg::CMD_ACK;
      srsw_pkg::OP_FINACK: cls.op = srsw_pkg::CMD_FINACK;
      srsw_pkg::OP_TICK:   cls.op = srsw_pkg::CMD_TICK;
      default:             cls.op = srsw_pkg::CMD_NOP;
    endcase
  end

  assign item_i.ready = (count_q != 2'd2);
  assign push = item_i.valid && item_i.ready;
  assign pop = cmd_pop_i && (count_q != 2'd0);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

endmodule
`default_nettype wire

// File: sv/srsw_back.sv
// Back part: window state, slot memory, ack and timer walks, result register.
`default_nettype none
module srsw_back #(
  parameter int unsigned WindowSlots = srsw_pkg::WindowSlotsDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire srsw_pkg::cmd_t                 cmd_i,
  input  wire logic                           cmd_valid_i,
  output logic                                cmd_pop_o,
  input  wire logic [srsw_pkg::TimeoutW-1:0]  timeout_i,
  input  wire logic [srsw_pkg::LimitW-1:0]    limit_i,
  srsw_out_if.source                          res_o
);

  localparam int unsigned SlotW = (WindowSlots > 1) ? $clog2(WindowSlots) : 1;
  localparam int unsigned Depth = 1 << SlotW;
  localparam int unsigned MemW = srsw_pkg::SeqW + 1;
  localparam logic [srsw_pkg::LimitW-1:0] LimMax = srsw_pkg::LimitW'(WindowSlots);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACKW = 3'd1;
  localparam logic [2:0] S_TICKW = 3'd2;
  localparam logic [2:0] S_TICKF = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_q, state_d;
  logic [srsw_pkg::SeqW-1:0] base_q, base_d, next_q, next_d, tick_q, tick_d;
  logic [srsw_pkg::SeqW-1:0] fst_q, fst_d, org_q, org_d;
  logic ended_q, ended_d, fsent_q, fsent_d, facked_q, facked_d;
  logic [srsw_pkg::CntW-1:0] k_q, k_d, infl_q, infl_d;
  logic cont_q, cont_d, all_q, all_d;
  logic pend_v_q, pend_v_d;
  logic [srsw_pkg::KindW-1:0] pend_kind_q, pend_kind_d;
  logic [srsw_pkg::SeqW-1:0] pend_seq_q, pend_seq_d;

  logic ov_q, ov_d;
  logic [srsw_pkg::KindW-1:0] okind_q, okind_d;
  logic [srsw_pkg::SeqW-1:0] oseq_q, oseq_d, obase_q, obase_d;
  logic olast_q, olast_d, odone_q, odone_d;

  logic [MemW-1:0] mem_q [Depth];
  logic [MemW-1:0] rd_q;
  logic [SlotW-1:0] rd_addr, waddr;
  logic [MemW-1:0] wdata;
  logic we;

  logic out_can;
  logic [srsw_pkg::LimitW-1:0] lim;
  logic [srsw_pkg::CntW-1:0] infl_now;
  logic [srsw_pkg::SeqW-1:0] ack_dist, span, seq_k, sack_off;
  logic ack_ahead, ack_inside, covered;
  logic new_v;
  logic [srsw_pkg::KindW-1:0] new_kind;
  logic [srsw_pkg::SeqW-1:0] new_seq;
  logic push, push_last;
  logic [srsw_pkg::KindW-1:0] push_kind;
  logic [srsw_pkg::SeqW-1:0] push_seq;

  assign out_can = !ov_q || res_o.ready;

  always_comb begin
    if (limit_i == '0) begin
      lim = srsw_pkg::LimitW'(1);
    end else if (limit_i > LimMax) begin
      lim = LimMax;
    end else begin
      lim = limit_i;
    end
  end

  assign infl_now = next_q[srsw_pkg::CntW-1:0] - base_q[srsw_pkg::CntW-1:0];
  assign ack_dist = cmd_i.ack_cum - base_q;
  assign span = next_q - base_q;
  assign ack_ahead = (ack_dist != '0) && !ack_dist[srsw_pkg::SeqW-1];
  assign ack_inside = ack_ahead && (ack_dist < span);
  assign seq_k = org_q + srsw_pkg::SeqW'(k_q);
  assign sack_off = seq_k - cmd_i.ack_cum;
  assign covered = (sack_off[srsw_pkg::SeqW-1:6] == '0) && cmd_i.sack_map[sack_off[5:0]];

  always_comb begin
    state_d = state_q;
    base_d = base_q;
    next_d = next_q;
    tick_d = tick_q;
    fst_d = fst_q;
    org_d = org_q;
    ended_d = ended_q;
    fsent_d = fsent_q;
    facked_d = facked_q;
    k_d = k_q;
    infl_d = infl_q;
    cont_d = cont_q;
    all_d = all_q;
    pend_v_d = pend_v_q;
    pend_kind_d = pend_kind_q;
    pend_seq_d = pend_seq_q;
    we = 1'b0;
    waddr = next_q[SlotW-1:0];
    wdata = {1'b0, tick_q};
    new_v = 1'b0;
    new_kind = srsw_pkg::KIND_STATUS;
    new_seq = '0;
    push = 1'b0;
    push_last = 1'b0;
    push_kind = pend_kind_q;
    push_seq = pend_seq_q;
    cmd_pop_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          state_d = S_DONE;
          case (cmd_i.op)
            srsw_pkg::CMD_CHUNK: begin
              if (!ended_q) begin
                new_v = 1'b1;
                new_seq = next_q;
                if (infl_now >= lim) begin
                  new_kind = srsw_pkg::KIND_FULL;
                end else begin
                  new_kind = srsw_pkg::KIND_SEND;
                  we = 1'b1;
                  next_d = next_q + srsw_pkg::SeqW'(1);
                end
              end
            end
            srsw_pkg::CMD_END: ended_d = 1'b1;
            srsw_pkg::CMD_FINACK: facked_d = 1'b1;
            srsw_pkg::CMD_ACK: begin
              // A cumulative ack that is not ahead of the base leaves the base in place;
              // one beyond the newest sequence only empties it.
              if (!ack_ahead) begin
                base_d = base_q;
                infl_d = infl_now;
              end else if (ack_inside) begin
                base_d = cmd_i.ack_cum;
                infl_d = infl_now - ack_dist[srsw_pkg::CntW-1:0];
              end else begin
                base_d = next_q;
                infl_d = '0;
              end
              org_d = base_d;
              k_d = '0;
              cont_d = 1'b1;
              state_d = S_ACKW;
            end
            srsw_pkg::CMD_TICK: begin
              tick_d = tick_q + srsw_pkg::SeqW'(1);
              org_d = base_q;
              infl_d = infl_now;
              k_d = '0;
              all_d = 1'b1;
              state_d = S_TICKW;
            end
            default: ;
          endcase
        end
      end
      S_ACKW: begin
        if (k_q >= infl_q) begin
          state_d = S_DONE;
        end else begin
          if (covered) begin
            we = 1'b1;
            waddr = seq_k[SlotW-1:0];
            wdata = {1'b1, rd_q[srsw_pkg::SeqW-1:0]};
          end
          if (cont_q && (rd_q[srsw_pkg::SeqW] || covered)) begin
            base_d = base_q + srsw_pkg::SeqW'(1);
          end else begin
            cont_d = 1'b0;
          end
          k_d = k_q + srsw_pkg::CntW'(1);
        end
      end
      S_TICKW: begin
        if (k_q >= infl_q) begin
          state_d = S_TICKF;
        end else if (out_can) begin
          if (!rd_q[srsw_pkg::SeqW]) begin
            all_d = 1'b0;
            if ((tick_q - rd_q[srsw_pkg::SeqW-1:0]) > srsw_pkg::SeqW'(timeout_i)) begin
              we = 1'b1;
              waddr = seq_k[SlotW-1:0];
              wdata = {1'b0, tick_q};
              new_v = 1'b1;
              new_kind = srsw_pkg::KIND_RESEND;
              new_seq = seq_k;
            end
          end
          k_d = k_q + srsw_pkg::CntW'(1);
        end
      end
      S_TICKF: begin
        if (out_can) begin
          if ((!fsent_q && ended_q && all_q) ||
              (fsent_q && !facked_q &&
               ((tick_q - fst_q) > srsw_pkg::SeqW'(timeout_i)))) begin
            fsent_d = 1'b1;
            fst_d = tick_q;
            new_v = 1'b1;
            new_kind = srsw_pkg::KIND_FIN;
            new_seq = next_q;
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_can) begin
          push = 1'b1;
          push_last = 1'b1;
          if (!pend_v_q) begin
            push_kind = srsw_pkg::KIND_STATUS;
            push_seq = '0;
          end
          pend_v_d = 1'b0;
          cmd_pop_o = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // A new result first sends the held one on, so that the last one is known.
    if (new_v) begin
      if (pend_v_q) begin
        push = 1'b1;
      end
      pend_v_d = 1'b1;
      pend_kind_d = new_kind;
      pend_seq_d = new_seq;
    end
  end

  assign rd_addr = org_d[SlotW-1:0] + k_d[SlotW-1:0];

  always_comb begin
    ov_d = ov_q;
    okind_d = okind_q;
    oseq_d = oseq_q;
    obase_d = obase_q;
    odone_d = odone_q;
    olast_d = olast_q;
    if (push) begin
      ov_d = 1'b1;
      okind_d = push_kind;
      oseq_d = push_seq;
      obase_d = base_q;
      odone_d = facked_q;
      olast_d = push_last;
    end else if (res_o.ready) begin
      ov_d = 1'b0;
    end
  end

  assign res_o.valid = ov_q;
  assign res_o.kind = okind_q;
  assign res_o.seq_number = oseq_q;
  assign res_o.window_base = obase_q;
  assign res_o.done_res = odone_q;
  assign res_o.last = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      base_q <= '0;
      next_q <= '0;
      tick_q <= '0;
      fst_q <= '0;
      ended_q <= 1'b0;
      fsent_q <= 1'b0;
      facked_q <= 1'b0;
      pend_v_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      base_q <= base_d;
      next_q <= next_d;
      tick_q <= tick_d;
      fst_q <= fst_d;
      ended_q <= ended_d;
      fsent_q <= fsent_d;
      facked_q <= facked_d;
      pend_v_q <= pend_v_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    org_q <= org_d;
    k_q <= k_d;
    infl_q <= infl_d;
    cont_q <= cont_d;
    all_q <= all_d;
    pend_kind_q <= pend_kind_d;
    pend_seq_q <= pend_seq_d;
    okind_q <= okind_d;
    oseq_q <= oseq_d;
    obase_q <= obase_d;
    odone_q <= odone_d;
    olast_q <= olast_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[rd_addr];
  end

endmodule
`default_nettype wire

// File: sv/srsw_checker.sv
// Port checker for the sender window and its bind to the top level.
`default_nettype none
module srsw_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [srsw_pkg::KindW-1:0]     out_kind,
  input wire logic [srsw_pkg::SeqW-1:0]      out_seq,
  input wire logic                           out_last
);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_kind_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_kind) && $stable(out_seq))
    else $error("result beat changed while stalled");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_kind == srsw_pkg::KIND_STATUS ||
                  out_kind == srsw_pkg::KIND_SEND ||
                  out_kind == srsw_pkg::KIND_FULL) |-> out_last)
    else $error("single-result kind without last");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind == srsw_pkg::KIND_STATUS |-> out_seq == '0)
    else $error("status result with non-zero sequence");

endmodule

bind selective_repeat_sender_window srsw_checker u_srsw_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (res_o.valid),
  .out_ready (res_o.ready),
  .out_kind  (res_o.kind),
  .out_seq   (res_o.seq_number),
  .out_last  (res_o.last)
);
`default_nettype wire

// File: dv/selective_repeat_sender_window_tb.sv
// Self-checking testbench for the selective-repeat sender window.
`default_nettype none
module selective_repeat_sender_window_tb;

  // Opcodes 5 to 7 carry no meaning; the block must answer them with a status beat.
  localparam logic [srsw_pkg::OpW-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [srsw_pkg::OpW-1:0] OP_SPARE_HI = 3'd7;
  localparam int unsigned Slots = srsw_pkg::WindowSlotsDefault;
  localparam int unsigned SlotW = $clog2(Slots);
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainCycles = 100;

  typedef struct packed {
    logic [srsw_pkg::OpW-1:0]   op;
    logic [srsw_pkg::SeqW-1:0]  ack_cum;
    logic [srsw_pkg::SackW-1:0] sack_map;
  } arq_item_t;

  typedef struct packed {
    logic [srsw_pkg::KindW-1:0] kind;
    logic [srsw_pkg::SeqW-1:0]  seq_number;
    logic [srsw_pkg::SeqW-1:0]  window_base;
    logic                       done_res;
    logic                       last;
  } arq_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we;
  logic [srsw_pkg::CfgIdxW-1:0] cfg_idx;
  logic [srsw_pkg::CfgDataW-1:0] cfg_data;

  srsw_in_if in_bus ();
  srsw_out_if res_bus ();

  selective_repeat_sender_window i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (in_bus.sink),
    .res_o     (res_bus.source),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always #4 clk_i = ~clk_i;

  // Items waiting to be offered, and the results the window is expected to produce.
  arq_item_t   tx_items[$];
  arq_result_t sender_results[$];

  // Shadow copy of the sender window, kept in step with the order of items queued.
  logic [srsw_pkg::TimeoutW-1:0] cfg_timeout;
  logic [srsw_pkg::LimitW-1:0]   cfg_limit;
  logic [srsw_pkg::SeqW-1:0]     sw_base, sw_next, fin_tick, tick_cnt;
  logic                          sw_ended, fin_out, fin_done;
  logic                          slot_ok[Slots];
  logic [srsw_pkg::SeqW-1:0]     slot_tick[Slots];

  int unsigned n_items, n_results, n_resends, n_fins, n_full, n_errors;
  bit  calm;
  bit  hold_go, hold_seen;
  int unsigned hold_len, hold_cnt;

  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Works out the result beats of one item and advances the shadow window.
  function automatic void predict_window(arq_item_t it);
    logic [srsw_pkg::KindW-1:0] kinds[$];
    logic [srsw_pkg::SeqW-1:0]  seqs[$];
    logic [srsw_pkg::SeqW-1:0]  lim, inflight, d, s;
    logic                       all_ok;
    int                         guard;
    arq_result_t                r;

    lim = (cfg_limit == '0) ? srsw_pkg::SeqW'(1) :
          (cfg_limit > Slots) ? srsw_pkg::SeqW'(Slots) : srsw_pkg::SeqW'(cfg_limit);
    case (it.op)
      srsw_pkg::OP_CHUNK: begin
        if (!sw_ended) begin
          if (sw_next - sw_base >= lim) begin
            kinds.push_back(srsw_pkg::KIND_FULL);
            seqs.push_back(sw_next);
          end else begin
            slot_ok[sw_next[SlotW-1:0]] = 1'b0;
            slot_tick[sw_next[SlotW-1:0]] = tick_cnt;
            kinds.push_back(srsw_pkg::KIND_SEND);
            seqs.push_back(sw_next);
            sw_next++;
          end
        end
      end
      srsw_pkg::OP_END: sw_ended = 1'b1;
      srsw_pkg::OP_ACK: begin
        // The cumulative base only moves the window when it lies ahead in serial terms.
        guard = 0;
        while (sw_base != sw_next && guard < Slots) begin
          d = it.ack_cum - sw_base;
          if (d == 0 || d[31]) break;
          slot_ok[sw_base[SlotW-1:0]] = 1'b1;
          sw_base++;
          guard++;
        end
        inflight = sw_next - sw_base;
        for (int i = 0; i < 64; i++) begin
          s = it.ack_cum + i;
          if (it.sack_map[i] && (s - sw_base) < inflight) slot_ok[s[SlotW-1:0]] = 1'b1;
        end
        guard = 0;
        while (sw_base != sw_next && guard < Slots && slot_ok[sw_base[SlotW-1:0]]) begin
          sw_base++;
          guard++;
        end
      end
      srsw_pkg::OP_FINACK: fin_done = 1'b1;
      srsw_pkg::OP_TICK: begin
        inflight = sw_next - sw_base;
        all_ok = 1'b1;
        tick_cnt++;
        for (int k = 0; k < inflight && k < Slots; k++) begin
          s = sw_base + k;
          if (!slot_ok[s[SlotW-1:0]]) begin
            all_ok = 1'b0;
            if (tick_cnt - slot_tick[s[SlotW-1:0]] > cfg_timeout) begin
              slot_tick[s[SlotW-1:0]] = tick_cnt;
              kinds.push_back(srsw_pkg::KIND_RESEND);
              seqs.push_back(s);
            end
          end
        end
        if (!fin_out && sw_ended && all_ok) begin
          fin_out = 1'b1;
          fin_tick = tick_cnt;
          kinds.push_back(srsw_pkg::KIND_FIN);
          seqs.push_back(sw_next);
        end
        if (fin_out && !fin_done && tick_cnt - fin_tick > cfg_timeout) begin
          fin_tick = tick_cnt;
          kinds.push_back(srsw_pkg::KIND_FIN);
          seqs.push_back(sw_next);
        end
      end
      default: ;
    endcase
    while (kinds.size() > 64) begin
      void'(kinds.pop_back());
      void'(seqs.pop_back());
    end
    if (kinds.size() == 0) begin
      kinds.push_back(srsw_pkg::KIND_STATUS);
      seqs.push_back('0);
    end
    foreach (kinds[k]) begin
      r.kind = kinds[k];
      r.seq_number = seqs[k];
      r.window_base = sw_base;
      r.done_res = fin_done;
      r.last = (k == kinds.size() - 1);
      sender_results.push_back(r);
    end
  endfunction

  task automatic queue_item(logic [srsw_pkg::OpW-1:0] op, logic [srsw_pkg::SeqW-1:0] ab,
                            logic [srsw_pkg::SackW-1:0] sm);
    arq_item_t it;
    it.op = op;
    it.ack_cum = ab;
    it.sack_map = sm;
    predict_window(it);
    tx_items.push_back(it);
    n_items++;
  endtask

  // An ack that mostly lands within the window, with a random SACK map.
  task automatic queue_ack();
    logic [srsw_pkg::SeqW-1:0] ab;
    logic [srsw_pkg::SackW-1:0] sm;
    if ($urandom_range(0, 9) == 0) ab = $urandom;
    else ab = sw_base + $urandom_range(0, sw_next - sw_base + 1);
    sm = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) sm = sm & {$urandom, $urandom};
    queue_item(srsw_pkg::OP_ACK, ab, sm);
  endtask

  // Random traffic of a transfer in progress: mostly chunks, ticks and acks.
  task automatic queue_traffic(int unsigned count);
    int unsigned r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 40) queue_item(srsw_pkg::OP_CHUNK, $urandom, {$urandom, $urandom});
      else if (r < 68) queue_item(srsw_pkg::OP_TICK, $urandom, {$urandom, $urandom});
      else if (r < 95) queue_ack();
      else queue_item(srsw_pkg::OpW'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), $urandom,
                      {$urandom, $urandom});
    end
  endtask

  // Waits until every queued item has gone in and every result has come out.
  task automatic drain();
    int unsigned waited;
    while (tx_items.size() != 0 || sender_results.size() != 0 || in_bus.valid) begin
      @(posedge clk_i);
    end
    waited = 0;
    while (waited < DrainCycles) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  task automatic write_reg(logic [srsw_pkg::CfgIdxW-1:0] idx,
                           logic [srsw_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == srsw_pkg::CFG_TIMEOUT) cfg_timeout = data[srsw_pkg::TimeoutW-1:0];
    else if (idx == srsw_pkg::CFG_LIMIT) cfg_limit = data[srsw_pkg::LimitW-1:0];
  endtask

  logic in_took;
  always @(posedge clk_i) in_took <= in_bus.valid && in_bus.ready;

  // Input driver: holds an offered item until it is taken, then pops it.
  int unsigned in_gap;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_bus.opcode <= srsw_pkg::OP_CHUNK;
      in_bus.ack_cum <= '0;
      in_bus.sack_map <= '0;
    end else begin
      if (in_bus.valid && in_took) begin
        void'(tx_items.pop_front());
        in_gap = rand_gap();
      end
      if (in_bus.valid && !in_took) begin
        // Keep offering the same beat.
      end else if (in_gap > 0) begin
        in_gap--;
        in_bus.valid <= 1'b0;
      end else if (tx_items.size() != 0) begin
        in_bus.valid <= 1'b1;
        in_bus.opcode <= tx_items[0].op;
        in_bus.ack_cum <= tx_items[0].ack_cum;
        in_bus.sack_map <= tx_items[0].sack_map;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // The long hold-off runs in a process of its own, counted in cycles.
  always @(negedge clk_i) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_cnt <= hold_len;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  int unsigned out_gap;
  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      out_gap--;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= (hold_cnt == 0) && !(hold_go != hold_seen);
      out_gap = rand_gap();
    end
  end

  // Result monitor: each beat is checked against the oldest expectation.
  always @(posedge clk_i) begin
    arq_result_t got, want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      got.kind = res_bus.kind;
      got.seq_number = res_bus.seq_number;
      got.window_base = res_bus.window_base;
      got.done_res = res_bus.done_res;
      got.last = res_bus.last;
      n_results++;
      if (got.kind == srsw_pkg::KIND_RESEND) n_resends++;
      if (got.kind == srsw_pkg::KIND_FIN) n_fins++;
      if (got.kind == srsw_pkg::KIND_FULL) n_full++;
      if (sender_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result beat: kind %0d seq %0d base %0d",
                                     got.kind, got.seq_number, got.window_base);
      end else begin
        want = sender_results.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10)
            $display("result mismatch: expected kind %0d seq %0d base %0d done %0d last %0d,%s",
                     want.kind, want.seq_number, want.window_base, want.done_res, want.last,
                     $sformatf(" got kind %0d seq %0d base %0d done %0d last %0d",
                               got.kind, got.seq_number, got.window_base, got.done_res,
                               got.last));
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  int unsigned cycle_cnt;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("selective_repeat_sender_window_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned rst_cycles;
    cfg_we = 1'b0;
    cfg_idx = srsw_pkg::CFG_TIMEOUT;
    cfg_data = '0;
    hold_go = 1'b0;
    hold_len = 0;
    calm = 1'b0;
    n_items = 0;
    cfg_timeout = srsw_pkg::TimeoutReset;
    cfg_limit = srsw_pkg::LimitReset;
    sw_base = '0;
    sw_next = '0;
    fin_tick = '0;
    tick_cnt = '0;
    sw_ended = 1'b0;
    fin_out = 1'b0;
    fin_done = 1'b0;
    foreach (slot_ok[i]) begin
      slot_ok[i] = 1'b0;
      slot_tick[i] = '0;
    end
    rst_cycles = 0;
    while (rst_cycles < 12) begin
      @(posedge clk_i);
      rst_cycles++;
    end
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: a few sends, the spare opcodes, acks outside and inside the window.
    calm = 1'b1;
    repeat (3) queue_item(srsw_pkg::OP_CHUNK, '0, '0);
    for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
      queue_item(srsw_pkg::OpW'(op), '1, '1);
    queue_item(srsw_pkg::OP_ACK, 32'h8000_0001, '1);
    queue_item(srsw_pkg::OP_ACK, 32'd1, 64'h2);
    queue_item(srsw_pkg::OP_ACK, 32'd1, 64'h1);
    repeat (2) queue_item(srsw_pkg::OP_TICK, '0, '0);
    drain();

    // Zero timeout with a window limit of zero, which acts as one.
    write_reg(srsw_pkg::CFG_TIMEOUT, 16'd0);
    write_reg(srsw_pkg::CFG_LIMIT, 16'd0);
    calm = 1'b0;
    repeat (2) queue_item(srsw_pkg::OP_CHUNK, '0, '0);
    repeat (3) queue_item(srsw_pkg::OP_TICK, '0, '0);
    queue_item(srsw_pkg::OP_ACK, sw_next, '0);
    drain();

    // Oversized limit acts as the full window: fill it, then resend every slot at once.
    write_reg(srsw_pkg::CFG_LIMIT, 16'h007F);
    repeat (66) queue_item(srsw_pkg::OP_CHUNK, $urandom, {$urandom, $urandom});
    repeat (2) queue_item(srsw_pkg::OP_TICK, '0, '0);
    queue_item(srsw_pkg::OP_ACK, sw_next, '0);
    drain();

    // Largest timeout: nothing is resent.
    write_reg(srsw_pkg::CFG_TIMEOUT, 16'hFFFF);
    write_reg(srsw_pkg::CFG_LIMIT, 16'd64);
    queue_traffic(60);
    queue_item(srsw_pkg::OP_ACK, sw_next, '0);
    drain();

    // Short timeout and a narrow window, with the receiver stalled long enough to back up.
    write_reg(srsw_pkg::CFG_TIMEOUT, 16'd3);
    write_reg(srsw_pkg::CFG_LIMIT, 16'd8);
    hold_len = 800;
    hold_go = ~hold_go;
    queue_traffic(130);
    drain();

    write_reg(srsw_pkg::CFG_TIMEOUT, 16'd1);
    write_reg(srsw_pkg::CFG_LIMIT, 16'd17);
    calm = 1'b1;
    queue_traffic(60);
    calm = 1'b0;
    queue_traffic(60);
    drain();

    // Close the transfer: end of data, everything acked, FIN sent, resent and acknowledged.
    write_reg(srsw_pkg::CFG_TIMEOUT, 16'd2);
    write_reg(srsw_pkg::CFG_LIMIT, 16'd64);
    queue_traffic(30);
    queue_item(srsw_pkg::OP_END, '0, '0);
    queue_item(srsw_pkg::OP_CHUNK, '0, '0);
    repeat (3) queue_item(srsw_pkg::OP_TICK, '0, '0);
    queue_item(srsw_pkg::OP_ACK, sw_next, '0);
    repeat (8) queue_item(srsw_pkg::OP_TICK, '0, '0);
    queue_item(srsw_pkg::OP_FINACK, '0, '0);
    repeat (3) queue_item(srsw_pkg::OP_TICK, '0, '0);
    queue_ack();
    queue_item(srsw_pkg::OP_FINACK, '0, '0);
    drain();

    $display("Drove %0d items through settings from zero to maximum timeout and limit.",
             n_items);
    $display("Checked %0d result beats: %0d resends, %0d FINs, %0d window-full refusals.",
             n_results, n_resends, n_fins, n_full);
    if (n_errors == 0) begin
      $display("selective_repeat_sender_window_tb: PASS");
    end else begin
      $display("%0d mismatching beats in total.", n_errors);
      $display("selective_repeat_sender_window_tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
